@@ hdl/mpq_pkg.sv @@
package mpq_pkg;

    localparam int KEY_W  = 16;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;
    localparam int FILL_W = 4;

    localparam int DEF_QUEUE_DEPTH = 8;

    // Request codes.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] entry_key;
        logic [TAG_W-1:0] entry_tag;
    } t_req;

    typedef struct packed {
        logic              pop_valid;
        logic [KEY_W-1:0]  out_key;
        logic [TAG_W-1:0]  out_tag;
        logic [STAT_W-1:0] status;
        logic [FILL_W-1:0] fill_level;
    } t_res;

    // Handshake status from the engine to the channel logic.
    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

@@ hdl/mpq_if.sv @@
interface mpq_in_if;
    import mpq_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [KEY_W-1:0] entry_key;
    logic [TAG_W-1:0] entry_tag;

    modport source (output valid, output req_type, output entry_key, output entry_tag,
                    input ready);
    modport sink (input valid, input req_type, input entry_key, input entry_tag,
                  output ready);
endinterface

interface mpq_out_if;
    import mpq_pkg::*;

    logic              valid;
    logic              ready;
    logic              pop_valid;
    logic [KEY_W-1:0]  out_key;
    logic [TAG_W-1:0]  out_tag;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, output pop_valid, output out_key, output out_tag,
                    output status, output fill_level, input ready);
    modport sink (input valid, input pop_valid, input out_key, input out_tag,
                  input status, input fill_level, output ready);
endinterface

@@ hdl/max_priority_queue_core.sv @@
// Channel   Dir  Beat payload                                   Accepted when
// i_req     in   req_type, entry_key, entry_tag                 valid && ready
// o_res     out  pop_valid, out_key, out_tag, status, fill_level valid && ready
//
// A push, a refused push and a refused pop go from idle straight to the final step.
// A pop that removes the entry at position k (oldest is 0) first scans all held
// entries and then compacts those above k, through the single read port of the
// entry memory, one entry per cycle.
// Reset is synchronous and active low; it empties the queue, the stored entries
// themselves are not cleared. The input is taken whenever the engine is idle, even
// while a result still waits in the output register; a stalled output holds the
// engine at its final step.
module max_priority_queue_core #(
    parameter int QUEUE_DEPTH = mpq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpq_in_if.sink    i_req,
    mpq_out_if.source o_res
);
    import mpq_pkg::*;

    t_req      w_req;
    t_res      w_eng_res;
    t_eng_stat w_stat;
    logic      w_start;
    logic      w_res_ok;

    // Output register: one result beat parked until the sink takes it.
    logic r_out_valid, n_out_valid;
    t_res r_out;

    assign w_req.req_type  = i_req.req_type;
    assign w_req.entry_key = i_req.entry_key;
    assign w_req.entry_tag = i_req.entry_tag;

    // The engine is ready for a new request whenever it is idle.
    assign i_req.ready = w_stat.idle;
    assign w_start     = i_req.valid && w_stat.idle;

    // The engine may finish only into a free (or freeing) output register.
    assign w_res_ok = !r_out_valid || o_res.ready;

    mpq_engine #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_req    (w_req),
        .i_res_ok (w_res_ok),
        .o_stat   (w_stat),
        .o_res    (w_eng_res)
    );

    assign n_out_valid = (r_out_valid && !o_res.ready) || w_stat.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_out <= w_eng_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.pop_valid  = r_out.pop_valid;
    assign o_res.out_key    = r_out.out_key;
    assign o_res.out_tag    = r_out.out_tag;
    assign o_res.status     = r_out.status;
    assign o_res.fill_level = r_out.fill_level;

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> w_res_ok)
        else $error("result completed into an occupied output register");

    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_OK)) |-> !r_out.pop_valid)
        else $error("refused request carries an entry");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !w_stat.idle)
        else $error("engine idle right after accepting a request");
`endif

endmodule

@@ hdl/mpq_engine.sv @@
module mpq_engine #(
    parameter int QUEUE_DEPTH = mpq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mpq_pkg::t_req      i_req,
    input  logic               i_res_ok,
    output mpq_pkg::t_eng_stat o_stat,
    output mpq_pkg::t_res      o_res
);
    import mpq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DW = KEY_W + TAG_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // Entry memory: key in the upper half, tag in the lower half.
    logic [DW-1:0] mem [QUEUE_DEPTH];

    logic [1:0]       r_state,    n_state;
    logic [CW-1:0]    r_count,    n_count;
    logic [DW-1:0]    r_rd_data;
    logic [CW-1:0]    r_scan_rd,  n_scan_rd;
    logic [CW-1:0]    r_scan_ix,  n_scan_ix;
    logic [KEY_W-1:0] r_best_key, n_best_key;
    logic [TAG_W-1:0] r_best_tag, n_best_tag;
    logic [CW-1:0]    r_best_ix,  n_best_ix;
    logic [CW-1:0]    r_sh,       n_sh;
    logic             r_pend,     n_pend;
    logic [CW-1:0]    r_wr_ix,    n_wr_ix;
    t_res             r_res,      n_res;

    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [DW-1:0]    w_wr_data;
    logic             w_done;
    logic [KEY_W-1:0] w_rd_key;
    logic [TAG_W-1:0] w_rd_tag;
    logic [CW+FILL_W-1:0] w_cnt_ext;

    assign w_rd_key = r_rd_data[DW-1:TAG_W];
    assign w_rd_tag = r_rd_data[TAG_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_scan_rd  = r_scan_rd;
        n_scan_ix  = r_scan_ix;
        n_best_key = r_best_key;
        n_best_tag = r_best_tag;
        n_best_ix  = r_best_ix;
        n_sh       = r_sh;
        n_pend     = r_pend;
        n_wr_ix    = r_wr_ix;
        n_res      = r_res;
        w_rd_en    = 1'b0;
        w_rd_addr  = '0;
        w_wr_en    = 1'b0;
        w_wr_addr  = '0;
        w_wr_data  = '0;
        w_done     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res = '0;
                    if (i_req.req_type == REQ_PUSH) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_count[AW-1:0];
                            w_wr_data = {i_req.entry_key, i_req.entry_tag};
                            n_count   = r_count + 1'b1;
                        end
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_res.status = ST_EMPTY;
                        n_state      = S_DONE;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_scan_rd = CW'(1);
                        n_scan_ix = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Strict compare keeps the oldest of equal keys.
                if ((r_scan_ix == '0) || (w_rd_key > r_best_key)) begin
                    n_best_key = w_rd_key;
                    n_best_tag = w_rd_tag;
                    n_best_ix  = r_scan_ix;
                end
                if (r_scan_rd < r_count) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_scan_rd[AW-1:0];
                    n_scan_rd = r_scan_rd + 1'b1;
                end
                n_scan_ix = r_scan_ix + 1'b1;
                if (r_scan_ix == r_count - 1'b1) begin
                    n_sh              = n_best_ix + 1'b1;
                    n_pend            = 1'b0;
                    n_res.pop_valid   = 1'b1;
                    n_res.out_key     = n_best_key;
                    n_res.out_tag     = n_best_tag;
                    n_res.status      = ST_OK;
                    n_state           = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // Read slot r_sh now, write it one place lower next cycle.
                if (r_pend) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_wr_ix[AW-1:0];
                    w_wr_data = r_rd_data;
                end
                if (r_sh < r_count) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_sh[AW-1:0];
                    n_pend    = 1'b1;
                    n_wr_ix   = r_sh - 1'b1;
                    n_sh      = r_sh + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ok) begin
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_rd  <= n_scan_rd;
        r_scan_ix  <= n_scan_ix;
        r_best_key <= n_best_key;
        r_best_tag <= n_best_tag;
        r_best_ix  <= n_best_ix;
        r_sh       <= n_sh;
        r_wr_ix    <= n_wr_ix;
        r_res      <= n_res;
    end

    assign w_cnt_ext = {{FILL_W{1'b0}}, r_count};

    always_comb begin
        o_res            = r_res;
        o_res.fill_level = w_cnt_ext[FILL_W-1:0];
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = w_done;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_ix < r_count))
        else $error("scan index beyond held entries");

    a_pend_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SHIFT))
        else $error("pending write-back outside compaction");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_sh <= r_count))
        else $error("compaction pointer beyond held entries");
`endif

endmodule
